>>> rtl/gfras_pkg.sv
// Package for the GB2312 / ASCII font ROM address stream.
// Holds word types, font ROM layout constants and register indexes.
// Used by gfras_decode and gb2312_font_rom_address_stream.
package gfras_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned AddrW   = 18;
  localparam int unsigned CellW   = 13;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [ByteW-1:0] Zone1Lo = 8'hB0;
  localparam logic [ByteW-1:0] Zone1Hi = 8'hF7;
  localparam logic [ByteW-1:0] Zone2Lo = 8'hA1;
  localparam logic [ByteW-1:0] Zone2Hi = 8'hA3;
  localparam logic [ByteW-1:0] TrailLo = 8'hA1;
  localparam logic [ByteW-1:0] AsciiLo = 8'h20;
  localparam logic [ByteW-1:0] AsciiHi = 8'h7E;

  localparam logic [CellW-1:0] RowCells  = 13'd94;
  localparam logic [CellW-1:0] Zone1Base = 13'd846;
  localparam logic [AddrW-1:0] AsciiBase = 18'h3CF80;

  localparam logic [ByteW-1:0] WideStep   = 8'd16;
  localparam logic [ByteW-1:0] NarrowStep = 8'd8;

  localparam logic [ByteW-1:0] StartXReset  = 8'd0;
  localparam logic [ByteW-1:0] TextRowReset = 8'd0;

  localparam logic [CfgIdxW-1:0] CFG_START_X  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_TEXT_ROW = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] text_byte;
    logic             string_end;
  } in_word_t;

  typedef struct packed {
    logic [AddrW-1:0] rom_address;
    logic             wide_glyph;
    logic [ByteW-1:0] glyph_x;
    logic [ByteW-1:0] glyph_y;
  } out_word_t;

  typedef struct packed {
    logic [ByteW-1:0] lead_byte;
    logic             lead_pending;
    logic [ByteW-1:0] cursor_x;
  } parse_state_t;

  function automatic logic is_lead(logic [ByteW-1:0] b);
    return ((b >= Zone1Lo) && (b <= Zone1Hi)) || ((b >= Zone2Lo) && (b <= Zone2Hi));
  endfunction

endpackage

>>> rtl/gfras_decode.sv
// Byte parser and font ROM address mapping for one text word.
// Combinational: current parse state in, result and next state out.
// Depends on gfras_pkg.
module gfras_decode (
  input  gfras_pkg::in_word_t     word_i,
  input  gfras_pkg::parse_state_t state_i,
  input  logic [7:0]              start_x_i,
  input  logic [7:0]              text_row_i,
  output logic                    res_valid_o,
  output gfras_pkg::out_word_t    res_word_o,
  output gfras_pkg::parse_state_t state_o
);

  logic [gfras_pkg::ByteW-1:0] b;
  logic                        zone1;
  logic [6:0]                  lead_off;
  logic [gfras_pkg::CellW-1:0] glyph_idx;
  logic [gfras_pkg::ByteW-1:0] trail_off;
  logic [6:0]                  ascii_off;
  logic [gfras_pkg::AddrW-1:0] wide_addr;
  logic [gfras_pkg::AddrW-1:0] narrow_addr;
  logic                        trail_ok;
  logic                        is_ascii;

  assign b         = word_i.text_byte;
  assign zone1     = state_i.lead_byte >= gfras_pkg::Zone1Lo;
  assign lead_off  = zone1 ? 7'(state_i.lead_byte - gfras_pkg::Zone1Lo)
                           : 7'(state_i.lead_byte - gfras_pkg::Zone2Lo);
  assign trail_off = b - gfras_pkg::TrailLo;
  assign glyph_idx = gfras_pkg::CellW'(lead_off) * gfras_pkg::RowCells
                   + gfras_pkg::CellW'(trail_off)
                   + (zone1 ? gfras_pkg::Zone1Base : '0);
  assign wide_addr   = {glyph_idx, 5'b0};
  assign ascii_off   = 7'(b - gfras_pkg::AsciiLo);
  assign narrow_addr = gfras_pkg::AsciiBase + gfras_pkg::AddrW'({ascii_off, 4'b0});
  assign trail_ok    = state_i.lead_pending && (b >= gfras_pkg::TrailLo);
  assign is_ascii    = (b >= gfras_pkg::AsciiLo) && (b <= gfras_pkg::AsciiHi);

  always_comb begin
    res_valid_o            = 1'b0;
    res_word_o.rom_address = narrow_addr;
    res_word_o.wide_glyph  = 1'b0;
    res_word_o.glyph_x     = state_i.cursor_x;
    res_word_o.glyph_y     = text_row_i;
    state_o                = state_i;
    if (word_i.string_end) begin
      state_o.lead_pending = 1'b0;
      state_o.lead_byte    = '0;
      state_o.cursor_x     = start_x_i;
    end else begin
      state_o.lead_pending = 1'b0;
      state_o.lead_byte    = '0;
      if (trail_ok) begin
        res_valid_o            = 1'b1;
        res_word_o.rom_address = wide_addr;
        res_word_o.wide_glyph  = 1'b1;
        state_o.cursor_x       = state_i.cursor_x + gfras_pkg::WideStep;
      end else if (gfras_pkg::is_lead(b)) begin
        state_o.lead_pending = 1'b1;
        state_o.lead_byte    = b;
      end else if (is_ascii) begin
        res_valid_o      = 1'b1;
        state_o.cursor_x = state_i.cursor_x + gfras_pkg::NarrowStep;
      end
    end
  end

endmodule

>>> rtl/gb2312_font_rom_address_stream.sv
// Top level of the GB2312 / ASCII font ROM address stream.
// Input register, parser (gfras_decode), parse state and result register.
// Depends on gfras_pkg and gfras_decode.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_word_i carries one text byte
//   per word, or a string end mark. Output channel out_valid_o / out_stall_i
//   / out_word_o carries one glyph per word: font ROM address, width flag,
//   x position and row. A GB2312 pair yields one word on its trail byte;
//   printable ASCII yields one word; other bytes yield none.
//   An accepted byte is parsed from the input register into the result
//   register. Throughput: one byte per cycle unless a result meets a stalled
//   output, set by the single parse step between the input and result
//   registers, which also updates the lead byte and cursor for the next
//   byte. When the receiver stalls, the result register holds; the input
//   register keeps moving while its byte gives no result, otherwise
//   in_stall_o rises. Config writes (start_x, text_row) are always ready;
//   the user must make them while the block is idle, which the block does
//   not enforce. Reset clears the pipeline, drops any pending lead, sets
//   cursor and start_x to StartXReset and text_row to TextRowReset.
module gb2312_font_rom_address_stream #(
  parameter logic [7:0] StartXReset  = gfras_pkg::StartXReset,
  parameter logic [7:0] TextRowReset = gfras_pkg::TextRowReset
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  gfras_pkg::in_word_t            in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output gfras_pkg::out_word_t           out_word_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gfras_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);

  logic                    s1_valid_q;
  gfras_pkg::in_word_t     s1_word_q;
  gfras_pkg::parse_state_t state_q, state_d;
  logic [7:0]              start_x_q, text_row_q;
  logic                    out_valid_q;
  gfras_pkg::out_word_t    out_word_q;
  logic                    res_valid;
  gfras_pkg::out_word_t    res_word;
  logic                    adv;
  logic                    in_acc;

  gfras_decode u_decode (
    .word_i      (s1_word_q),
    .state_i     (state_q),
    .start_x_i   (start_x_q),
    .text_row_i  (text_row_q),
    .res_valid_o (res_valid),
    .res_word_o  (res_word),
    .state_o     (state_d)
  );

  assign adv        = s1_valid_q && (!res_valid || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_word_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.lead_byte    <= '0;
      state_q.lead_pending <= 1'b0;
      state_q.cursor_x     <= StartXReset;
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q  <= StartXReset;
      text_row_q <= TextRowReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        gfras_pkg::CFG_START_X:  start_x_q  <= cfg_data_i;
        gfras_pkg::CFG_TEXT_ROW: text_row_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_pending_is_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.lead_pending |-> gfras_pkg::is_lead(state_q.lead_byte))
    else $error("pending lead byte outside lead ranges");

  a_wide_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.wide_glyph) |-> (out_word_o.rom_address[4:0] == 5'd0))
    else $error("wide glyph address not 32-byte aligned");

  a_end_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_word_q.string_end) |=>
      (state_q.cursor_x == $past(start_x_q)) && !state_q.lead_pending)
    else $error("string end did not reload cursor");

  a_no_result_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_word_q.string_end) |-> !res_valid)
    else $error("string end produced a glyph");

endmodule
